// File: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared definitions for the bitmap page allocator
// Sizes of the block map and owner table, result codes and beat formats.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGE_BYTES  = 1024;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam logic [15:0] PAGE_MASK   = 16'(PAGE_BYTES - 1);
  localparam int unsigned MAP_SIDE    = 8;
  localparam int unsigned NBLOCKS     = MAP_SIDE * MAP_SIDE;
  localparam int unsigned BLK_W       = 6;
  localparam int unsigned PAGE_LIMIT  = 8;
  localparam int unsigned PAGE_W      = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned OWNER_SLOTS = 8;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned FREE_W      = 7;
  localparam int unsigned RAM_DEPTH   = OWNER_SLOTS * PAGE_LIMIT;
  localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);
  localparam logic [3:0]  MAXP_RESET  = 4'd8;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_BIG    = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_ZERO_SIZE  = 3'd5
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] owner_id;
    logic [15:0] size_bytes;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  page_index;
    logic [5:0]  block_number;
    logic        last;
    logic [6:0]  free_count;
  } rsp_t;

endpackage

// File: sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bitmap_page_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top: block store allocator with per-owner page tables
//
//   channel   direction  handshake              beat
//   cfg       in         cfg_we_i               cfg_data_i (max pages per owner)
//   request   in         in_valid_i/in_ready_o  in_data_i  (bpa_pkg::req_t)
//   result    out        out_valid_o/out_ready_i out_data_o (bpa_pkg::rsp_t)
//
// One request is taken at a time. After the accept cycle the owner table is
// walked one slot per cycle by a single owner-id comparator. An allocation
// then walks the used-bit map one block per cycle, while the result register
// can load, until its last page is granted; a free reads the page table RAM
// and releases one block per page, alternating a read state and a write state.
// Reset empties the map and the owner table at once; no clearing pass.
// A stalled result register holds the sequencer in S_ALLOC and S_RESP until
// the beat is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bpa_pkg::rsp_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_e;

  state_e                              state_q;
  bpa_pkg::op_e                        op_q;
  logic [15:0]                         id_q;
  logic [bpa_pkg::FREE_W-1:0]          pages_q;
  logic                                pre_err_q;
  bpa_pkg::status_e                    pre_status_q;
  bpa_pkg::status_e                    resp_status_q;
  logic [bpa_pkg::SLOT_W-1:0]          scan_q;
  logic                                hit_q;
  logic [bpa_pkg::SLOT_W-1:0]          hit_slot_q;
  logic                                empty_q;
  logic [bpa_pkg::SLOT_W-1:0]          empty_slot_q;
  logic [bpa_pkg::BLK_W-1:0]           blk_q;
  logic [bpa_pkg::PAGE_W-1:0]          page_q;
  logic                                out_valid_q;
  bpa_pkg::rsp_t                       out_data_q;
  logic [3:0]                          max_q;
  logic [bpa_pkg::FREE_W-1:0]          free_blocks_q;
  logic [bpa_pkg::NBLOCKS-1:0]         block_used_q;
  logic [bpa_pkg::OWNER_SLOTS-1:0]     slot_valid_q;
  logic [15:0]                         slot_owner_q [bpa_pkg::OWNER_SLOTS];
  logic [bpa_pkg::COUNT_W-1:0]         slot_count_q [bpa_pkg::OWNER_SLOTS];

  logic                                can_load;
  logic                                accept;
  logic [bpa_pkg::FREE_W-1:0]          req_pages;
  logic [3:0]                          limit;
  logic                                scan_hit;
  logic                                hit_now;
  logic [bpa_pkg::SLOT_W-1:0]          hit_slot_now;
  logic                                empty_now;
  logic [bpa_pkg::SLOT_W-1:0]          empty_slot_now;
  logic                                scan_end;
  logic                                blk_free;
  logic                                alloc_last;
  logic                                alloc_emit;
  logic                                resp_emit;
  logic                                out_load;
  logic                                free_last;
  logic [bpa_pkg::FREE_W-1:0]          free_after;
  logic [bpa_pkg::RAM_AW-1:0]          ram_waddr;
  logic [bpa_pkg::RAM_AW-1:0]          ram_raddr;
  logic [bpa_pkg::BLK_W-1:0]           ram_rdata;

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Round the byte count up to whole pages.
  assign req_pages = bpa_pkg::FREE_W'(in_data_i.size_bytes >> bpa_pkg::PAGE_SHIFT)
                   + bpa_pkg::FREE_W'(|(in_data_i.size_bytes & bpa_pkg::PAGE_MASK));
  assign limit = (max_q > 4'(bpa_pkg::PAGE_LIMIT)) ? 4'(bpa_pkg::PAGE_LIMIT) : max_q;

  // Owner table walk: the first matching slot and the first empty slot.
  assign scan_hit       = slot_valid_q[scan_q] && (slot_owner_q[scan_q] == id_q);
  assign hit_now        = hit_q || scan_hit;
  assign hit_slot_now   = hit_q ? hit_slot_q : scan_q;
  assign empty_now      = empty_q || !slot_valid_q[scan_q];
  assign empty_slot_now = empty_q ? empty_slot_q : scan_q;
  assign scan_end       = (scan_q == bpa_pkg::SLOT_W'(bpa_pkg::OWNER_SLOTS - 1));

  assign blk_free   = !block_used_q[blk_q];
  assign alloc_last = (bpa_pkg::FREE_W'(page_q) + 1'b1) == pages_q;
  assign alloc_emit = (state_q == S_ALLOC) && blk_free && can_load;
  assign resp_emit  = (state_q == S_RESP) && can_load;
  assign out_load   = alloc_emit || resp_emit;
  assign free_last  = (bpa_pkg::COUNT_W'(page_q) + 1'b1) == slot_count_q[hit_slot_q];
  assign free_after = free_blocks_q - pages_q;

  assign ram_waddr = bpa_pkg::RAM_AW'(empty_slot_q) * bpa_pkg::RAM_AW'(bpa_pkg::PAGE_LIMIT)
                   + bpa_pkg::RAM_AW'(page_q);
  assign ram_raddr = bpa_pkg::RAM_AW'(hit_slot_q) * bpa_pkg::RAM_AW'(bpa_pkg::PAGE_LIMIT)
                   + bpa_pkg::RAM_AW'(page_q);

  bpa_ram #(
    .WIDTH(bpa_pkg::BLK_W),
    .DEPTH(bpa_pkg::RAM_DEPTH)
  ) u_pages (
    .clk_i  (clk_i),
    .we_i   (alloc_emit),
    .waddr_i(ram_waddr),
    .wdata_i(blk_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      max_q         <= bpa_pkg::MAXP_RESET;
      free_blocks_q <= bpa_pkg::FREE_W'(bpa_pkg::NBLOCKS);
      block_used_q  <= '0;
      slot_valid_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_FIND;
          end
        end
        S_FIND: begin
          if (scan_end) begin
            if (op_q == bpa_pkg::OP_FREE) begin
              state_q <= hit_now ? S_FREE_RD : S_RESP;
            end else if (pre_err_q || hit_now || !empty_now) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          if (alloc_emit) begin
            block_used_q[blk_q]     <= 1'b1;
            out_data_q.status       <= bpa_pkg::ST_OK;
            out_data_q.page_index   <= page_q;
            out_data_q.block_number <= blk_q;
            out_data_q.last         <= alloc_last;
            out_data_q.free_count   <= free_after;
            if (alloc_last) begin
              slot_valid_q[empty_slot_q] <= 1'b1;
              free_blocks_q              <= free_after;
              state_q                    <= S_IDLE;
            end
          end
        end
        S_FREE_RD: begin
          state_q <= S_FREE_WR;
        end
        S_FREE_WR: begin
          if (block_used_q[ram_rdata]) begin
            block_used_q[ram_rdata] <= 1'b0;
            free_blocks_q           <= free_blocks_q + 1'b1;
          end
          if (free_last) begin
            slot_valid_q[hit_slot_q] <= 1'b0;
            state_q                  <= S_RESP;
          end else begin
            state_q <= S_FREE_RD;
          end
        end
        S_RESP: begin
          if (can_load) begin
            out_data_q.status       <= resp_status_q;
            out_data_q.page_index   <= '0;
            out_data_q.block_number <= '0;
            out_data_q.last         <= 1'b1;
            out_data_q.free_count   <= free_blocks_q;
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request context and owner table contents.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q    <= in_data_i.operation;
        id_q    <= in_data_i.owner_id;
        pages_q <= req_pages;
        scan_q  <= '0;
        hit_q   <= 1'b0;
        empty_q <= 1'b0;
        if (in_data_i.size_bytes == 16'd0) begin
          pre_err_q    <= 1'b1;
          pre_status_q <= bpa_pkg::ST_ZERO_SIZE;
        end else if (req_pages > bpa_pkg::FREE_W'(limit)) begin
          pre_err_q    <= 1'b1;
          pre_status_q <= bpa_pkg::ST_TOO_BIG;
        end else if (req_pages > free_blocks_q) begin
          pre_err_q    <= 1'b1;
          pre_status_q <= bpa_pkg::ST_NO_SPACE;
        end else begin
          pre_err_q    <= 1'b0;
          pre_status_q <= bpa_pkg::ST_OK;
        end
      end
      S_FIND: begin
        hit_q        <= hit_now;
        hit_slot_q   <= hit_slot_now;
        empty_q      <= empty_now;
        empty_slot_q <= empty_slot_now;
        scan_q       <= scan_q + 1'b1;
        blk_q        <= '0;
        page_q       <= '0;
        if (op_q == bpa_pkg::OP_FREE) begin
          resp_status_q <= hit_now ? bpa_pkg::ST_OK : bpa_pkg::ST_NOT_FOUND;
        end else if (pre_err_q) begin
          resp_status_q <= pre_status_q;
        end else begin
          resp_status_q <= bpa_pkg::ST_TABLE_FULL;
        end
      end
      S_ALLOC: begin
        if (alloc_emit) begin
          page_q <= page_q + 1'b1;
          blk_q  <= blk_q + 1'b1;
          if (alloc_last) begin
            slot_owner_q[empty_slot_q] <= id_q;
            slot_count_q[empty_slot_q] <= bpa_pkg::COUNT_W'(pages_q);
          end
        end else if (blk_free == 1'b0) begin
          blk_q <= blk_q + 1'b1;
        end
      end
      S_FREE_WR: begin
        page_q <= page_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Between requests the free counter agrees with the used-bit map.
  a_free_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |->
      free_blocks_q == bpa_pkg::FREE_W'(bpa_pkg::NBLOCKS - $countones(block_used_q)))
    else $error("free block counter disagrees with the used-bit map");

  // An allocation walk only starts when enough blocks are free to finish it.
  a_alloc_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC |-> (pages_q <= free_blocks_q) && !pre_err_q)
    else $error("allocation walk running without enough free blocks");

  // The last released page of a free empties the owner's slot.
  a_free_clears_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FREE_WR && free_last |=> !slot_valid_q[hit_slot_q])
    else $error("owner slot still valid after its free completed");

  // Every rejection beat must be marked last; frees also answer with a single, final beat.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bpa_pkg::ST_OK |-> out_data_o.last)
    else $error("error result beat not marked last");

endmodule
